[sv/krt_pkg.sv]
// Shared types and constants for the keyed record table.
// No dependencies; imported by the top level, the engine and the checker.
package krt_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 16;
    localparam int SCORE_W   = 16;
    localparam int REC_W     = KEY_W + SCORE_W;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 7;

    localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
    localparam logic [OP_W-1:0] OP_MODIFY    = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE    = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd3;
    localparam logic [OP_W-1:0] OP_SORT_UP   = 3'd4;
    localparam logic [OP_W-1:0] OP_SORT_DOWN = 3'd5;
    // spare op codes, accepted and ignored
    localparam logic [OP_W-1:0] OP_RSVD6     = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7     = 3'd7;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SORT_LD,
        S_SORT_CAP,
        S_SORT_RD,
        S_SORT_CMP,
        S_SORT_WB,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [SCORE_W-1:0]   found_score;
        logic                 passed;
        logic [ENTRIES_W-1:0] entries;
    } result_t;

endpackage

[sv/keyed_record_table_with_sort.sv]
// Top level of the keyed record table: stream ports, pass mark register, result register.
// Depends on krt_pkg and krt_engine.
//
// Use: one request on the s_axis channel carries an operation (tuser) with a key and
// score (tdata); exactly one result comes out on m_axis for every request, in order.
// cfg_valid/cfg_data writes the pass mark; cfg_ready is always high. Write it only
// while no request is in flight.
// The record RAM has a single read port, so every record visit is a read state followed
// by a compare/write state. Add and unknown ops do no scan; a search or modify reads
// the records in turn up to the key or the end; a delete then moves each later record
// down one place; a sort runs compare passes over the records, swapping as it goes.
// One request is worked on at a time. The result register frees the engine, so the
// next request is taken while a result still waits on a stalled m_axis; a stalled
// receiver holds the engine only once a second result is ready. Reset empties the
// table (entry count zero) and sets the pass mark to 4000; the RAM itself is not cleared.
module keyed_record_table_with_sort
    import krt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key[15:0], score[31:16]
    input  logic [2:0]  s_axis_tuser,   // op[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // status[1:0], found_score[17:2], passed[18],
                                        // entries[25:19], zero[31:26]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [SCORE_W-1:0] pass_mark_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    logic               out_free;
    logic               eng_ready;
    logic               eng_done;
    request_t           req;
    result_t            eng_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_mark_reg <= SCORE_W'(4000);
        end
        else if (cfg_valid)
        begin
            pass_mark_reg <= cfg_data;
        end
    end

    assign req.op    = s_axis_tuser;
    assign req.key   = s_axis_tdata[KEY_W-1:0];
    assign req.score = s_axis_tdata[REC_W-1:KEY_W];

    assign s_axis_tready = eng_ready;
    // result slot free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    krt_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_axis_tvalid && eng_ready),
        .req       (req),
        .pass_mark (pass_mark_reg),
        .out_free  (out_free),
        .ready     (eng_ready),
        .done      (eng_done),
        .result    (eng_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            out_reg <= eng_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.entries, out_reg.passed,
                            out_reg.found_score, out_reg.status};

endmodule

[sv/krt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module krt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/krt_engine.sv]
// Operation sequencer: scans, shifts and exchange-sorts records held in the RAM.
// Depends on krt_pkg and krt_ram.
module krt_engine
    import krt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  request_t            req,
    input  logic [SCORE_W-1:0]  pass_mark,
    input  logic                out_free,
    output logic                ready,
    output logic                done,
    output result_t             result
);

    state_t              state_reg, state_next;
    request_t            req_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    jdx_reg;
    logic [REC_W-1:0]    hold_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SCORE_W-1:0]  found_reg;
    logic                passed_reg;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [REC_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [REC_W-1:0]    ram_rdata;

    logic [KEY_W-1:0]    rd_key;
    logic [SCORE_W-1:0]  rd_score;
    logic [SCORE_W-1:0]  hold_score;
    logic                key_hit;
    logic                swap;
    logic                full;
    logic [CNT_W-1:0]    idx_p1;
    logic [CNT_W-1:0]    idx_p2;
    logic [CNT_W-1:0]    jdx_p1;

    krt_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key     = ram_rdata[REC_W-1:SCORE_W];
    assign rd_score   = ram_rdata[SCORE_W-1:0];
    assign hold_score = hold_reg[SCORE_W-1:0];
    assign key_hit    = (rd_key == req_reg.key);
    assign swap       = (req_reg.op == OP_SORT_DOWN) ? (hold_score < rd_score)
                                                     : (hold_score > rd_score);
    assign full       = (count_reg >= CNT_W'(CAPACITY));
    assign idx_p1     = idx_reg + CNT_W'(1);
    assign idx_p2     = idx_reg + CNT_W'(2);
    assign jdx_p1     = jdx_reg + CNT_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (req_reg.op)
                    OP_MODIFY, OP_DELETE, OP_SEARCH:
                        state_next = (count_reg == '0) ? S_DONE : S_RD;
                    OP_SORT_UP, OP_SORT_DOWN:
                        state_next = (count_reg < CNT_W'(2)) ? S_DONE : S_SORT_LD;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_RD:
                state_next = S_CHK;
            S_CHK:
            begin
                if (key_hit)
                begin
                    if (req_reg.op == OP_DELETE && idx_p1 < count_reg)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (idx_p1 < count_reg)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT_RD:
                state_next = S_SHIFT_WR;
            S_SHIFT_WR:
                state_next = (idx_p2 < count_reg) ? S_SHIFT_RD : S_DONE;
            S_SORT_LD:
                state_next = S_SORT_CAP;
            S_SORT_CAP:
                state_next = S_SORT_RD;
            S_SORT_RD:
                state_next = S_SORT_CMP;
            S_SORT_CMP:
                state_next = (jdx_p1 < count_reg) ? S_SORT_RD : S_SORT_WB;
            S_SORT_WB:
                state_next = (idx_p2 < count_reg) ? S_SORT_LD : S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs: RAM port control and handshake strobes
    always_comb
    begin
        ready     = 1'b0;
        done      = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IDX_W-1:0];
        ram_wdata = hold_reg;
        ram_raddr = idx_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE:
                ready = 1'b1;
            S_EXEC:
            begin
                ram_waddr = count_reg[IDX_W-1:0];
                ram_wdata = {req_reg.key, req_reg.score};
                ram_we    = (req_reg.op == OP_ADD) && !full;
            end
            S_CHK:
            begin
                ram_wdata = {rd_key, req_reg.score};
                ram_we    = key_hit && (req_reg.op == OP_MODIFY);
            end
            S_SHIFT_RD:
                ram_raddr = idx_p1[IDX_W-1:0];
            S_SHIFT_WR:
            begin
                ram_wdata = ram_rdata;
                ram_we    = 1'b1;
            end
            S_SORT_RD:
                ram_raddr = jdx_reg[IDX_W-1:0];
            S_SORT_CMP:
            begin
                ram_waddr = jdx_reg[IDX_W-1:0];
                ram_we    = swap;
            end
            S_SORT_WB:
                ram_we = 1'b1;
            S_DONE:
                done = out_free;
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_EXEC:
                begin
                    if (req_reg.op == OP_ADD && !full)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                S_CHK:
                begin
                    if (key_hit && req_reg.op == OP_DELETE && !(idx_p1 < count_reg))
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                S_SHIFT_WR:
                begin
                    if (!(idx_p2 < count_reg))
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_reg <= req;
                end
            end
            S_EXEC:
            begin
                idx_reg    <= '0;
                found_reg  <= '0;
                passed_reg <= 1'b0;
                status_reg <= ST_DONE;
                case (req_reg.op)
                    OP_ADD:
                    begin
                        if (full)
                        begin
                            status_reg <= ST_FULL;
                        end
                        else
                        begin
                            passed_reg <= (req_reg.score >= pass_mark);
                        end
                    end
                    OP_MODIFY, OP_DELETE, OP_SEARCH:
                    begin
                        if (count_reg == '0)
                        begin
                            status_reg <= ST_MISSING;
                        end
                    end
                    default:
                    begin
                        status_reg <= ST_DONE;
                    end
                endcase
            end
            S_CHK:
            begin
                if (key_hit)
                begin
                    if (req_reg.op == OP_SEARCH)
                    begin
                        found_reg <= rd_score;
                    end
                end
                else if (idx_p1 < count_reg)
                begin
                    idx_reg <= idx_p1;
                end
                else
                begin
                    status_reg <= ST_MISSING;
                end
            end
            S_SHIFT_WR:
                idx_reg <= idx_p1;
            S_SORT_CAP:
            begin
                hold_reg <= ram_rdata;
                jdx_reg  <= idx_p1;
            end
            S_SORT_CMP:
            begin
                if (swap)
                begin
                    hold_reg <= ram_rdata;
                end
                jdx_reg <= jdx_p1;
            end
            S_SORT_WB:
                idx_reg <= idx_p1;
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign result.status      = status_reg;
    assign result.found_score = found_reg;
    assign result.passed      = passed_reg;
    assign result.entries     = ENTRIES_W'(count_reg);

endmodule

[sv/krt_checker.sv]
// Port-level checks on the keyed record table, bound to the top level.
// Depends on krt_pkg.
module krt_checker
    import krt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] <= ST_FULL)
        else $error("undefined status code");

    // only a clean result carries a score or a pass flag
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_DONE |->
            m_axis_tdata[17:2] == 16'd0 && !m_axis_tdata[18])
        else $error("failed request carries data");

    // a full table reports the full count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL |->
            m_axis_tdata[25:19] == ENTRIES_W'(CAPACITY))
        else $error("full status with room left");

endmodule

bind keyed_record_table_with_sort krt_checker u_krt_checker (.*);
